/* hw/rtl/rle_line_number_table_assert.svh */
// ----------------------------------------------------------------------------
// rle_line_number_table_assert.svh
// Assertion macros used by the line table checker.
// ----------------------------------------------------------------------------
`ifndef RLE_LINE_NUMBER_TABLE_ASSERT_SVH
`define RLE_LINE_NUMBER_TABLE_ASSERT_SVH

// same-cycle implication, reset masked
`define RLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rle_line_number_table: same-cycle check failed");

// next-cycle implication, reset masked
`define RLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rle_line_number_table: next-cycle check failed");

`endif

/* hw/rtl/rlt_pkg.sv */
// ----------------------------------------------------------------------------
// rlt_pkg
// Constants and controller/datapath handshake types of the line table.
// ----------------------------------------------------------------------------
package rlt_pkg;

  localparam int MAX_RUNS  = 256;
  localparam int MAX_BYTES = 65536;

  localparam int DATA_W  = 16;
  localparam int RUN_AW  = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int RUN_CW  = $clog2(MAX_RUNS + 1);
  localparam int BYTES_W = $clog2(MAX_BYTES + 1);
  localparam int ACC_W   = (BYTES_W > DATA_W + 1) ? BYTES_W : DATA_W + 1;

  localparam logic [DATA_W-1:0] COUNT_MAX = {DATA_W{1'b1}};

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef struct packed {
    logic append;   // apply append and load its result beat
    logic q_start;  // latch offset, clear sum and index
    logic rd_en;    // read run at index
    logic q_acc;    // fold run count into sum, advance index
    logic q_hit;    // record hit line
    logic q_miss;   // record miss
    logic push;     // load query result beat
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic mode;
    logic empty;
    logic hit;
    logic last;
  } status_t;

endpackage

/* hw/rtl/rlt_ifs.sv */
// ----------------------------------------------------------------------------
// rlt_ifs
// Valid/ready channels for line table items and results.
// ----------------------------------------------------------------------------
interface rlt_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [rlt_pkg::DATA_W-1:0] line_number;
  logic [rlt_pkg::DATA_W-1:0] byte_offset;

  modport source (output valid, output mode, output line_number, output byte_offset,
                  input ready);
  modport sink (input valid, input mode, input line_number, input byte_offset,
                output ready);
endinterface

interface rlt_out_if;
  logic                      valid;
  logic                      ready;
  logic [rlt_pkg::DATA_W-1:0] line_result;
  logic                      found;
  logic                      full_res;

  modport source (output valid, output line_result, output found, output full_res,
                  input ready);
  modport sink (input valid, input line_result, input found, input full_res,
                output ready);
endinterface

/* hw/rtl/rlt_dp.sv */
// ----------------------------------------------------------------------------
// rlt_dp
// Run store, append update, query sum and result register.
// ----------------------------------------------------------------------------
module rlt_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rlt_pkg::cmd_t               cmd,
  output rlt_pkg::status_t            st,
  input  logic                        in_mode,
  input  logic [rlt_pkg::DATA_W-1:0]  in_line_number,
  input  logic [rlt_pkg::DATA_W-1:0]  in_byte_offset,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [rlt_pkg::DATA_W-1:0]  out_line_result,
  output logic                        out_found,
  output logic                        out_full_res
);

  logic [rlt_pkg::DATA_W-1:0] count_mem [rlt_pkg::MAX_RUNS];
  logic [rlt_pkg::DATA_W-1:0] line_mem  [rlt_pkg::MAX_RUNS];

  logic [rlt_pkg::RUN_CW-1:0]  runs_used_r, runs_used_nxt;
  logic [rlt_pkg::BYTES_W-1:0] bytes_total_r, bytes_total_nxt;
  logic [rlt_pkg::DATA_W-1:0]  last_line_r, last_count_r;
  logic [rlt_pkg::DATA_W-1:0]  offset_r;
  logic [rlt_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [rlt_pkg::RUN_AW-1:0]  idx_r;
  logic [rlt_pkg::DATA_W-1:0]  cnt_rd_r, line_rd_r;
  logic [rlt_pkg::DATA_W-1:0]  res_line_r;
  logic                        res_found_r;
  logic                        out_valid_r;
  logic [rlt_pkg::DATA_W-1:0]  out_line_r;
  logic                        out_found_r, out_full_r;

  logic                        bytes_full, runs_full, extend_ok;
  logic                        app_ext, app_new, app_drop, wr_en;
  logic [rlt_pkg::RUN_AW-1:0]  wr_addr, last_idx, new_idx;
  logic [rlt_pkg::DATA_W-1:0]  wr_count;

  assign last_idx   = rlt_pkg::RUN_AW'(runs_used_r - rlt_pkg::RUN_CW'(1));
  assign new_idx    = rlt_pkg::RUN_AW'(runs_used_r);
  assign bytes_full = (bytes_total_r == rlt_pkg::BYTES_W'(rlt_pkg::MAX_BYTES));
  assign runs_full  = (runs_used_r == rlt_pkg::RUN_CW'(rlt_pkg::MAX_RUNS));
  assign extend_ok  = (runs_used_r != '0) && (last_line_r == in_line_number) &&
                      (last_count_r != rlt_pkg::COUNT_MAX);
  assign app_ext    = !bytes_full && extend_ok;
  assign app_new    = !bytes_full && !extend_ok && !runs_full;
  assign app_drop   = !(app_ext || app_new);
  assign wr_en      = cmd.append && !app_drop;
  assign wr_addr    = app_ext ? last_idx : new_idx;
  assign wr_count   = app_ext ? (last_count_r + rlt_pkg::DATA_W'(1))
                              : rlt_pkg::DATA_W'(1);

  always_comb begin
    runs_used_nxt   = runs_used_r;
    bytes_total_nxt = bytes_total_r;
    if (wr_en) begin
      bytes_total_nxt = bytes_total_r + rlt_pkg::BYTES_W'(1);
      if (app_new) begin
        runs_used_nxt = runs_used_r + rlt_pkg::RUN_CW'(1);
      end
    end
  end

  assign acc_nxt = acc_r + rlt_pkg::ACC_W'(cnt_rd_r);

  assign st.out_free = !out_valid_r || out_ready;
  assign st.mode     = in_mode;
  assign st.empty    = (runs_used_r == '0);
  assign st.hit      = (acc_nxt > rlt_pkg::ACC_W'(offset_r));
  assign st.last     = ((rlt_pkg::RUN_CW'(idx_r) + rlt_pkg::RUN_CW'(1)) == runs_used_r);

  // run store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      count_mem[wr_addr] <= wr_count;
      line_mem[wr_addr]  <= in_line_number;
    end
    if (cmd.rd_en) begin
      cnt_rd_r  <= count_mem[idx_r];
      line_rd_r <= line_mem[idx_r];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_line_r  <= in_line_number;
      last_count_r <= wr_count;
    end
    if (cmd.q_start) begin
      offset_r <= in_byte_offset;
      acc_r    <= '0;
      idx_r    <= '0;
    end else if (cmd.q_acc) begin
      acc_r <= acc_nxt;
      idx_r <= idx_r + rlt_pkg::RUN_AW'(1);
    end
    if (cmd.q_hit) begin
      res_line_r  <= line_rd_r;
      res_found_r <= 1'b1;
    end else if (cmd.q_miss) begin
      res_line_r  <= '0;
      res_found_r <= 1'b0;
    end
    if (cmd.append) begin
      out_line_r  <= '0;
      out_found_r <= 1'b0;
      out_full_r  <= app_drop;
    end else if (cmd.push) begin
      out_line_r  <= res_line_r;
      out_found_r <= res_found_r;
      out_full_r  <= 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      runs_used_r   <= '0;
      bytes_total_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      runs_used_r   <= runs_used_nxt;
      bytes_total_r <= bytes_total_nxt;
      if (cmd.append || cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_line_result = out_line_r;
  assign out_found       = out_found_r;
  assign out_full_res    = out_full_r;

endmodule

/* hw/rtl/rlt_ctrl.sv */
// ----------------------------------------------------------------------------
// rlt_ctrl
// Sequencer: takes items, walks runs for queries, hands off result beats.
// ----------------------------------------------------------------------------
module rlt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rlt_pkg::status_t st,
  output rlt_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_PUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE) && st.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (st.mode == rlt_pkg::MODE_APPEND) begin
            cmd.append = 1'b1;
          end else if (st.empty) begin
            cmd.q_miss = 1'b1;
            state_nxt  = S_PUSH;
          end else begin
            cmd.q_start = 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (st.hit) begin
          cmd.q_hit = 1'b1;
          state_nxt = S_PUSH;
        end else if (st.last) begin
          cmd.q_miss = 1'b1;
          state_nxt  = S_PUSH;
        end else begin
          cmd.q_acc = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_PUSH: begin
        if (st.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/rle_line_number_table.sv */
// ----------------------------------------------------------------------------
// rle_line_number_table
// Run-length table of (count, line) runs mapping byte offsets to lines.
// ----------------------------------------------------------------------------
//  port     dir  beat
//  in_ch    in   mode, line_number, byte_offset
//  out_ch   out  line_result, found, full_res
//
//  Append: the result beat is registered in the cycle after accept.
//  Query: per run visited, a registered run-store read (S_RD), then sum and
//  compare (S_CHK); then S_PUSH hands off the result beat.
//  Reset clears run/byte counts, out valid, state; no clearing pass over store.
//  A result beat held by out_ch stalls new items.
// ----------------------------------------------------------------------------
module rle_line_number_table (
  input logic       clk,
  input logic       rst_n,
  rlt_in_if.sink    in_ch,
  rlt_out_if.source out_ch
);

  rlt_pkg::cmd_t    cmd;
  rlt_pkg::status_t st;
  logic             in_ready;

  assign in_ch.ready = in_ready;

  rlt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rlt_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_mode         (in_ch.mode),
    .in_line_number  (in_ch.line_number),
    .in_byte_offset  (in_ch.byte_offset),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_line_result (out_ch.line_result),
    .out_found       (out_ch.found),
    .out_full_res    (out_ch.full_res)
  );

endmodule

/* hw/rtl/rlt_checker.sv */
// ----------------------------------------------------------------------------
// rlt_checker
// Port-level checks of the line table, bound to the top level.
// ----------------------------------------------------------------------------
`include "rle_line_number_table_assert.svh"

module rlt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rlt_pkg::DATA_W-1:0] out_line_result,
  input logic                       out_found,
  input logic                       out_full_res
);

  `RLT_ASSERT_NOW(a_no_hit_and_full, clk, rst_n, out_valid, !(out_found && out_full_res))
  `RLT_ASSERT_NOW(a_miss_line_zero, clk, rst_n, out_valid && !out_found, out_line_result == '0)
  `RLT_ASSERT_NOW(a_accept_slot_free, clk, rst_n, in_valid && in_ready, !out_valid || out_ready)
  `RLT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_line_result) && $stable(out_found) && $stable(out_full_res))

endmodule

bind rle_line_number_table rlt_checker u_rlt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_line_result (out_ch.line_result),
  .out_found       (out_ch.found),
  .out_full_res    (out_ch.full_res)
);
